### hdl/ttab_pkg.sv
// shared types and constants of the tick timebase alarm bank
`default_nettype none

package ttab_pkg;

  localparam int unsigned OpW       = 3;
  localparam int unsigned IdW       = 4;
  localparam int unsigned DurW      = 32;
  localparam int unsigned StatusW   = 2;
  localparam int unsigned JobSpace  = 4;
  localparam int unsigned PeriodW   = 16;
  localparam int unsigned ElapsedW  = 17;
  localparam int unsigned SecW      = 32;
  localparam int unsigned MillisW   = 10;
  localparam int unsigned NowW      = 32;
  localparam int unsigned CfgIdxW   = 2;
  localparam int unsigned InDataW   = 40;
  localparam int unsigned OutDataW  = 56;

  localparam logic [MillisW:0] MsPerSec = 11'd1000;

  typedef enum logic [OpW-1:0] {
    OP_TICK      = 3'd0,
    OP_ARM_MS    = 3'd1,
    OP_ARM_SEC   = 3'd2,
    OP_CHECK     = 3'd3,
    OP_CLEAR     = 3'd4
  } op_e;

  typedef enum logic [StatusW-1:0] {
    ST_RINGING = 2'd0,
    ST_QUIET   = 2'd1,
    ST_BAD_ID  = 2'd2,
    ST_DONE    = 2'd3
  } status_e;

  typedef struct packed {
    logic tick;
    logic arm;
    logic arm_sec;
    logic check;
    logic clear;
  } cmd_t;

endpackage

`default_nettype wire

### hdl/ttab_timebase.sv
// millisecond and seconds counters with a running time in ms
`default_nettype none

module ttab_timebase #(
  parameter int unsigned TICK_MS = 10
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       en_i,
  input  wire ttab_pkg::cmd_t             cmd_i,
  output logic                            feed_o,
  output logic [ttab_pkg::SecW-1:0]       seconds_o,
  output logic [ttab_pkg::MillisW-1:0]    millis_o,
  output logic [ttab_pkg::NowW-1:0]       now_o
);
  import ttab_pkg::*;

  logic [MillisW-1:0] millis_q, millis_d;
  logic [SecW-1:0]    seconds_q, seconds_d;
  logic [NowW-1:0]    now_q, now_d;
  logic [MillisW:0]   millis_sum;
  logic               wrap;

  assign millis_sum = {1'b0, millis_q} + (MillisW+1)'(TICK_MS);
  assign wrap       = (millis_sum >= MsPerSec);

  always_comb begin
    millis_d  = millis_q;
    seconds_d = seconds_q;
    now_d     = now_q;
    feed_o    = 1'b0;
    if (cmd_i.tick) begin
      if (wrap) begin
        millis_d  = '0;
        seconds_d = seconds_q + SecW'(1);
        now_d     = now_q + NowW'(MsPerSec) - NowW'(millis_q);
        feed_o    = 1'b1;
      end else begin
        millis_d = millis_sum[MillisW-1:0];
        now_d    = now_q + NowW'(TICK_MS);
      end
    end else if (cmd_i.clear) begin
      millis_d  = '0;
      seconds_d = '0;
      now_d     = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      millis_q  <= '0;
      seconds_q <= '0;
      now_q     <= '0;
    end else if (en_i) begin
      millis_q  <= millis_d;
      seconds_q <= seconds_d;
      now_q     <= now_d;
    end
  end

  assign seconds_o = seconds_d;
  assign millis_o  = millis_d;
  assign now_o     = now_q;

endmodule

`default_nettype wire

### hdl/ttab_jobs.sv
// periodic job slots with their period registers
`default_nettype none

module ttab_jobs #(
  parameter int unsigned JOB_SLOTS = 4,
  parameter int unsigned TICK_MS   = 10
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           en_i,
  input  wire ttab_pkg::cmd_t                 cmd_i,
  input  wire logic                           cfg_we_i,
  input  wire logic [ttab_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  wire logic [ttab_pkg::PeriodW-1:0]   cfg_data_i,
  output logic [ttab_pkg::JobSpace-1:0]       fire_o
);
  import ttab_pkg::*;

  logic [PeriodW-1:0]  period_q [JobSpace];
  logic [ElapsedW-1:0] elapsed_q [JOB_SLOTS];
  logic [ElapsedW-1:0] elapsed_d [JOB_SLOTS];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < JobSpace; k++) period_q[k] <= '0;
    end else if (cfg_we_i) begin
      period_q[cfg_index_i] <= cfg_data_i;
    end
  end

  always_comb begin
    fire_o = '0;
    for (int k = 0; k < JOB_SLOTS; k++) begin
      elapsed_d[k] = elapsed_q[k];
      if (cmd_i.tick) begin
        if (period_q[k] == '0) begin
          elapsed_d[k] = '0;
        end else begin
          elapsed_d[k] = elapsed_q[k] + ElapsedW'(TICK_MS);
          if (elapsed_d[k] >= {1'b0, period_q[k]}) begin
            elapsed_d[k] = '0;
            fire_o[k]    = 1'b1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < JOB_SLOTS; k++) elapsed_q[k] <= '0;
    end else if (en_i) begin
      for (int k = 0; k < JOB_SLOTS; k++) elapsed_q[k] <= elapsed_d[k];
    end
  end

endmodule

`default_nettype wire

### hdl/ttab_alarms.sv
// one-shot alarm slots: arm, check and disarm
`default_nettype none

module ttab_alarms #(
  parameter int unsigned ALARMS = 8
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         en_i,
  input  wire ttab_pkg::cmd_t               cmd_i,
  input  wire logic [ttab_pkg::IdW-1:0]     alarm_slot_i,
  input  wire logic [ttab_pkg::DurW-1:0]    duration_i,
  input  wire logic [ttab_pkg::NowW-1:0]    now_i,
  output ttab_pkg::status_e                 status_o
);
  import ttab_pkg::*;

  localparam int unsigned AW = (ALARMS > 1) ? $clog2(ALARMS) : 1;

  logic [ALARMS-1:0] armed_q;
  logic [NowW-1:0]   length_q [ALARMS];
  logic [NowW-1:0]   start_q [ALARMS];
  logic [AW-1:0]     idx;
  logic              id_ok;
  logic [NowW-1:0]   arm_len;
  logic [NowW-1:0]   elapsed;
  logic              ringing;

  assign id_ok   = (alarm_slot_i < IdW'(ALARMS));
  assign idx     = alarm_slot_i[AW-1:0];
  assign arm_len = cmd_i.arm_sec ? NowW'(duration_i * NowW'(MsPerSec)) : duration_i;
  assign elapsed = now_i - start_q[idx];
  assign ringing = armed_q[idx] && (elapsed >= length_q[idx]);

  always_comb begin
    status_o = ST_DONE;
    if ((cmd_i.arm || cmd_i.check) && !id_ok) begin
      status_o = ST_BAD_ID;
    end else if (cmd_i.check) begin
      status_o = ringing ? ST_RINGING : ST_QUIET;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      armed_q <= '0;
      for (int k = 0; k < ALARMS; k++) begin
        length_q[k] <= '0;
        start_q[k]  <= '0;
      end
    end else if (en_i && id_ok) begin
      if (cmd_i.arm) begin
        armed_q[idx]  <= 1'b1;
        length_q[idx] <= arm_len;
        start_q[idx]  <= now_i;
      end else if (cmd_i.check && ringing) begin
        armed_q[idx] <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

### hdl/tick_timebase_alarm_bank_core.sv
// top level of the tick timebase alarm bank
//
//  port group   dir  beat contents
//  s_axis       in   operation, alarm_slot, duration
//  m_axis       out  status, job_fire, watchdog_feed, seconds_now, millis_now
//  cfg          in   job_period_0..3 write
//
// each beat is captured in an input register, then handled into the result
// register; one beat per cycle sustained while the result is not stalled
// all counters, job slots and alarms clear on reset
// a stalled result holds; the input register still takes a beat when the
// result moves on in the same cycle
`default_nettype none

module tick_timebase_alarm_bank_core #(
  parameter int unsigned ALARMS    = 8,
  parameter int unsigned JOB_SLOTS = 4,
  parameter int unsigned TICK_MS   = 10
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            s_axis_tvalid,
  output logic                                 s_axis_tready,
  // operation[2:0], alarm_slot[6:3], duration[38:7]
  input  wire logic [ttab_pkg::InDataW-1:0]    s_axis_tdata,
  output logic                                 m_axis_tvalid,
  input  wire logic                            m_axis_tready,
  // status[1:0], job_fire[5:2], watchdog_feed[6], seconds_now[38:7],
  // millis_now[48:39]
  output logic [ttab_pkg::OutDataW-1:0]        m_axis_tdata,
  input  wire logic                            cfg_we_i,
  input  wire logic [ttab_pkg::CfgIdxW-1:0]    cfg_index_i,
  input  wire logic [ttab_pkg::PeriodW-1:0]    cfg_data_i
);
  import ttab_pkg::*;

  logic                in_valid_q;
  logic [OpW-1:0]      op_q;
  logic [IdW-1:0]      id_q;
  logic [DurW-1:0]     dur_q;
  logic                out_valid_q;
  logic [OutDataW-1:0] out_data_q;
  logic                out_free;
  logic                proceed;
  cmd_t                cmd;
  logic                feed;
  logic [SecW-1:0]     seconds;
  logic [MillisW-1:0]  millis;
  logic [NowW-1:0]     now;
  logic [JobSpace-1:0] fire;
  status_e             status;

  assign out_free      = !out_valid_q || m_axis_tready;
  assign proceed       = in_valid_q && out_free;
  assign s_axis_tready = !in_valid_q || out_free;

  always_comb begin
    cmd = '0;
    if (in_valid_q) begin
      unique case (op_q)
        OP_TICK:    cmd.tick    = 1'b1;
        OP_ARM_MS:  cmd.arm     = 1'b1;
        OP_ARM_SEC: begin
          cmd.arm     = 1'b1;
          cmd.arm_sec = 1'b1;
        end
        OP_CHECK:   cmd.check   = 1'b1;
        OP_CLEAR:   cmd.clear   = 1'b1;
        default:    cmd         = '0;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      op_q  <= s_axis_tdata[OpW-1:0];
      id_q  <= s_axis_tdata[OpW+IdW-1:OpW];
      dur_q <= s_axis_tdata[OpW+IdW+DurW-1:OpW+IdW];
    end
  end

  ttab_timebase #(
    .TICK_MS (TICK_MS)
  ) u_timebase (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .en_i      (proceed),
    .cmd_i     (cmd),
    .feed_o    (feed),
    .seconds_o (seconds),
    .millis_o  (millis),
    .now_o     (now)
  );

  ttab_jobs #(
    .JOB_SLOTS (JOB_SLOTS),
    .TICK_MS   (TICK_MS)
  ) u_jobs (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .en_i        (proceed),
    .cmd_i       (cmd),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .fire_o      (fire)
  );

  ttab_alarms #(
    .ALARMS (ALARMS)
  ) u_alarms (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .en_i         (proceed),
    .cmd_i        (cmd),
    .alarm_slot_i (id_q),
    .duration_i   (dur_q),
    .now_i        (now),
    .status_o     (status)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= proceed;
    end
  end

  always_ff @(posedge clk_i) begin
    if (proceed) begin
      out_data_q <= {7'd0, millis, seconds, feed, fire, status};
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

endmodule

`default_nettype wire
